### design/tpi_pkg.sv
// ----------------------------------------------------------------------------
// tpi_pkg: shared constants for the three plane intersection unit
// Cyclic index tables for cross products and the pipeline depth.
// ----------------------------------------------------------------------------
package tpi_pkg;

    localparam int unsigned AXES = 3;

    // next and second-next axis, cyclic
    localparam int unsigned NX1 [AXES] = '{1, 2, 0};
    localparam int unsigned NX2 [AXES] = '{2, 0, 1};

    // products, crosses, partial products, terms, sums, magnitude, divider entry
    localparam int unsigned PRE_DIV_DEPTH = 7;

    function automatic int unsigned tpi_latency(input int unsigned data_width);
        return PRE_DIV_DEPTH + data_width + 2;
    endfunction

endpackage

### design/three_plane_intersection_unit.sv
// ----------------------------------------------------------------------------
// three_plane_intersection_unit: point common to three planes
// Cramer's rule in signed fixed point with a bit-per-stage pipelined divider.
// ----------------------------------------------------------------------------
//  channel  | signals                                    | handshake
//  ---------+--------------------------------------------+------------------------
//  request  | start, busy, i_plane_{a,b,c}_*             | taken when start && !busy
//  result   | o_valid, o_point_{x,y,z}, o_degenerate,    | one cycle strobe, no stall
//           | o_saturated                                |
//
//  One request may enter every cycle; the result passes through seven arithmetic
//  stages, DATA_WIDTH + 1 restoring divider stages (one quotient bit each) and
//  the output register.
//  Synchronous reset empties the pipeline; busy is high only during reset.
//  The result side has no back-pressure, so the pipeline never stalls.
// ----------------------------------------------------------------------------
module three_plane_intersection_unit
    import tpi_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [DATA_WIDTH-1:0] i_plane_a_nx,
    input  logic signed [DATA_WIDTH-1:0] i_plane_a_ny,
    input  logic signed [DATA_WIDTH-1:0] i_plane_a_nz,
    input  logic signed [DATA_WIDTH-1:0] i_plane_a_dist,
    input  logic signed [DATA_WIDTH-1:0] i_plane_b_nx,
    input  logic signed [DATA_WIDTH-1:0] i_plane_b_ny,
    input  logic signed [DATA_WIDTH-1:0] i_plane_b_nz,
    input  logic signed [DATA_WIDTH-1:0] i_plane_b_dist,
    input  logic signed [DATA_WIDTH-1:0] i_plane_c_nx,
    input  logic signed [DATA_WIDTH-1:0] i_plane_c_ny,
    input  logic signed [DATA_WIDTH-1:0] i_plane_c_nz,
    input  logic signed [DATA_WIDTH-1:0] i_plane_c_dist,
    output logic                         o_valid,
    output logic signed [DATA_WIDTH-1:0] o_point_x,
    output logic signed [DATA_WIDTH-1:0] o_point_y,
    output logic signed [DATA_WIDTH-1:0] o_point_z,
    output logic                         o_degenerate,
    output logic                         o_saturated
);

    localparam int W   = DATA_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int P2  = 2 * W;
    localparam int CRW = 2 * W + 1;
    localparam int TW  = 3 * W + 1;
    localparam int DW  = 3 * W + 3;
    localparam int NW  = DW + F;
    localparam int LAT = int'(tpi_latency(DATA_WIDTH));

    localparam logic [W:0] POS_LIM = {2'b00, {(W - 1){1'b1}}};
    localparam logic [W:0] NEG_LIM = {2'b01, {(W - 1){1'b0}}};
    localparam logic signed [W-1:0] MAX_VAL = {1'b0, {(W - 1){1'b1}}};
    localparam logic signed [W-1:0] MIN_VAL = {1'b1, {(W - 1){1'b0}}};

    logic accept;
    logic [LAT:1] r_v;

    logic signed [W-1:0] w_n [AXES][AXES];
    logic signed [W-1:0] w_d [AXES];

    logic signed [P2-1:0]  r_pp  [AXES][AXES][2];
    logic signed [W-1:0]   r_d1  [AXES];
    logic signed [W-1:0]   r_na1 [AXES];
    logic signed [CRW-1:0] r_cr  [AXES][AXES];
    logic signed [W-1:0]   r_d2  [AXES];
    logic signed [W-1:0]   r_na2 [AXES];
    logic signed [CRW-1:0] r_dlo [AXES];
    logic signed [CRW-1:0] r_dhi [AXES];
    logic signed [CRW-1:0] r_nlo [AXES][AXES];
    logic signed [CRW-1:0] r_nhi [AXES][AXES];
    logic signed [TW-1:0]  r_dt  [AXES];
    logic signed [TW-1:0]  r_nt  [AXES][AXES];
    logic signed [DW-1:0]  r_det;
    logic signed [DW-1:0]  r_num [AXES];
    logic [DW-1:0]         r_dmag;
    logic [DW-1:0]         r_nmag [AXES];
    logic                  r_neg6 [AXES];
    logic                  r_dz6;

    logic [NW-1:0] w_nn [AXES];
    logic [NW-1:0] w_nh [AXES];

    // divider pipeline, index 0 is the entry register
    logic [DW-1:0] r_rem  [0:W+1][AXES];
    logic [W:0]    r_q    [0:W+1][AXES];
    logic [W:0]    r_bits [0:W+1][AXES];
    logic          r_ov   [0:W+1][AXES];
    logic          r_neg  [0:W+1][AXES];
    logic          r_dz   [0:W+1];
    logic [DW-1:0] r_dv   [0:W+1];

    logic signed [W-1:0] w_pt   [AXES];
    logic                w_psat [AXES];
    logic [W:0]          w_negq [AXES];

    logic signed [W-1:0] r_px, r_py, r_pz;
    logic                r_degen, r_sat;

    assign busy   = ~i_rst_n;
    assign accept = start & ~busy;

    assign w_n[0][0] = i_plane_a_nx;
    assign w_n[0][1] = i_plane_a_ny;
    assign w_n[0][2] = i_plane_a_nz;
    assign w_n[1][0] = i_plane_b_nx;
    assign w_n[1][1] = i_plane_b_ny;
    assign w_n[1][2] = i_plane_b_nz;
    assign w_n[2][0] = i_plane_c_nx;
    assign w_n[2][1] = i_plane_c_ny;
    assign w_n[2][2] = i_plane_c_nz;
    assign w_d[0]    = i_plane_a_dist;
    assign w_d[1]    = i_plane_b_dist;
    assign w_d[2]    = i_plane_c_dist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[LAT-1:1], accept};
        end
    end

    // cross j is n[j+1] x n[j+2]: b x c, c x a, a x b
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < AXES; j++) begin
            for (int k = 0; k < AXES; k++) begin
                r_pp[j][k][0] <= w_n[NX1[j]][NX1[k]] * w_n[NX2[j]][NX2[k]];
                r_pp[j][k][1] <= w_n[NX1[j]][NX2[k]] * w_n[NX2[j]][NX1[k]];
            end
            r_d1[j]  <= w_d[j];
            r_na1[j] <= w_n[0][j];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < AXES; j++) begin
            for (int k = 0; k < AXES; k++) begin
                r_cr[j][k] <= CRW'(r_pp[j][k][0]) - CRW'(r_pp[j][k][1]);
            end
            r_d2[j]  <= r_d1[j];
            r_na2[j] <= r_na1[j];
        end
    end

    // split each cross into a signed high half and an unsigned low half
    always_ff @(posedge i_clk) begin
        for (int t = 0; t < AXES; t++) begin
            r_dlo[t] <= r_na2[t] * $signed({1'b0, r_cr[0][t][W-1:0]});
            r_dhi[t] <= r_na2[t] * $signed(r_cr[0][t][CRW-1:W]);
        end
        for (int i = 0; i < AXES; i++) begin
            for (int j = 0; j < AXES; j++) begin
                r_nlo[i][j] <= r_d2[j] * $signed({1'b0, r_cr[j][i][W-1:0]});
                r_nhi[i][j] <= r_d2[j] * $signed(r_cr[j][i][CRW-1:W]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int t = 0; t < AXES; t++) begin
            r_dt[t] <= TW'(r_dlo[t]) + $signed({r_dhi[t], {W{1'b0}}});
        end
        for (int i = 0; i < AXES; i++) begin
            for (int j = 0; j < AXES; j++) begin
                r_nt[i][j] <= TW'(r_nlo[i][j]) + $signed({r_nhi[i][j], {W{1'b0}}});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_det <= DW'(r_dt[0]) + DW'(r_dt[1]) + DW'(r_dt[2]);
        for (int i = 0; i < AXES; i++) begin
            r_num[i] <= DW'(r_nt[i][0]) + DW'(r_nt[i][1]) + DW'(r_nt[i][2]);
        end
    end

    // point is -num / det: negative when num and det share a sign
    always_ff @(posedge i_clk) begin
        r_dmag <= r_det[DW-1] ? DW'(-r_det) : DW'(r_det);
        r_dz6  <= (r_det == '0);
        for (int i = 0; i < AXES; i++) begin
            r_nmag[i] <= r_num[i][DW-1] ? DW'(-r_num[i]) : DW'(r_num[i]);
            r_neg6[i] <= ((~r_num[i][DW-1]) & (|r_num[i])) ^ r_det[DW-1];
        end
    end

    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            w_nn[i] = {r_nmag[i], {F{1'b0}}};
            w_nh[i] = w_nn[i] >> (W + 1);
        end
    end

    // quotient wider than W+1 bits saturates; otherwise seed the remainder
    always_ff @(posedge i_clk) begin
        r_dz[0] <= r_dz6;
        r_dv[0] <= r_dmag;
        for (int i = 0; i < AXES; i++) begin
            r_ov[0][i]   <= (w_nh[i] >= NW'(r_dmag));
            r_rem[0][i]  <= w_nh[i][DW-1:0];
            r_bits[0][i] <= w_nn[i][W:0];
            r_q[0][i]    <= '0;
            r_neg[0][i]  <= r_neg6[i];
        end
    end

    for (genvar s = 0; s <= W; s++) begin : g_div
        for (genvar i = 0; i < AXES; i++) begin : g_ax
            logic [DW:0] w_rsh;
            logic [DW:0] w_dif;
            logic        w_ge;

            assign w_rsh = {r_rem[s][i], r_bits[s][i][W-s]};
            assign w_ge  = (w_rsh >= {1'b0, r_dv[s]});
            assign w_dif = w_rsh - {1'b0, r_dv[s]};

            always_ff @(posedge i_clk) begin
                r_rem[s+1][i]  <= w_ge ? w_dif[DW-1:0] : w_rsh[DW-1:0];
                r_q[s+1][i]    <= {r_q[s][i][W-1:0], w_ge};
                r_bits[s+1][i] <= r_bits[s][i];
                r_ov[s+1][i]   <= r_ov[s][i];
                r_neg[s+1][i]  <= r_neg[s][i];
            end
        end

        always_ff @(posedge i_clk) begin
            r_dz[s+1] <= r_dz[s];
            r_dv[s+1] <= r_dv[s];
        end
    end

    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            w_negq[i] = (W + 1)'(0) - r_q[W+1][i];
            if (r_dz[W+1]) begin
                w_pt[i]   = '0;
                w_psat[i] = 1'b0;
            end else if (r_neg[W+1][i]) begin
                if (r_ov[W+1][i] || (r_q[W+1][i] > NEG_LIM)) begin
                    w_pt[i]   = MIN_VAL;
                    w_psat[i] = 1'b1;
                end else begin
                    w_pt[i]   = $signed(w_negq[i][W-1:0]);
                    w_psat[i] = 1'b0;
                end
            end else begin
                if (r_ov[W+1][i] || (r_q[W+1][i] > POS_LIM)) begin
                    w_pt[i]   = MAX_VAL;
                    w_psat[i] = 1'b1;
                end else begin
                    w_pt[i]   = $signed(r_q[W+1][i][W-1:0]);
                    w_psat[i] = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_px    <= w_pt[0];
        r_py    <= w_pt[1];
        r_pz    <= w_pt[2];
        r_degen <= r_dz[W+1];
        r_sat   <= w_psat[0] | w_psat[1] | w_psat[2];
    end

    assign o_valid      = r_v[LAT];
    assign o_point_x    = r_px;
    assign o_point_y    = r_py;
    assign o_point_z    = r_pz;
    assign o_degenerate = r_degen;
    assign o_saturated  = r_sat;

endmodule

### design/tpi_checker.sv
// ----------------------------------------------------------------------------
// tpi_checker: port-level checks for the three plane intersection unit
// Fixed latency from request to result and consistency of the result flags.
// ----------------------------------------------------------------------------
module tpi_checker
    import tpi_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         o_valid,
    input logic signed [DATA_WIDTH-1:0] o_point_x,
    input logic signed [DATA_WIDTH-1:0] o_point_y,
    input logic signed [DATA_WIDTH-1:0] o_point_z,
    input logic                         o_degenerate,
    input logic                         o_saturated
);

    localparam int LAT = int'(tpi_latency(DATA_WIDTH));
    localparam logic signed [DATA_WIDTH-1:0] MAX_VAL = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] MIN_VAL = {1'b1, {(DATA_WIDTH - 1){1'b0}}};

    a_req_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("request without result at fixed latency");

    a_result_has_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT))
        else $error("result without matching request");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_degenerate) |->
        (o_point_x == '0 && o_point_y == '0 && o_point_z == '0 && !o_saturated))
        else $error("degenerate result not cleared");

    a_sat_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |->
        (o_point_x == MAX_VAL || o_point_x == MIN_VAL ||
         o_point_y == MAX_VAL || o_point_y == MIN_VAL ||
         o_point_z == MAX_VAL || o_point_z == MIN_VAL))
        else $error("saturated flag without clamped coordinate");

endmodule

bind three_plane_intersection_unit tpi_checker #(.DATA_WIDTH(DATA_WIDTH)) u_tpi_checker (.*);
